// ===== rtl/monochrome_framebuffer_streamer_core_macros.svh =====
// assertion macros used by the rtl top level
`ifndef MONOCHROME_FRAMEBUFFER_STREAMER_CORE_MACROS_SVH
`define MONOCHROME_FRAMEBUFFER_STREAMER_CORE_MACROS_SVH

// same-cycle implication
`define MFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfs assertion failed");

// next-cycle implication
`define MFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mfs assertion failed");

`endif

// ===== rtl/mfs_pkg.sv =====
package mfs_pkg;

	typedef enum logic [1:0] {
		OP_DRAW    = 2'd0,
		OP_FILL    = 2'd1,
		OP_READ    = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	localparam logic [1:0] PEN_ERASE  = 2'd0;
	localparam logic [1:0] PEN_SET    = 2'd1;
	localparam logic [1:0] PEN_INVERT = 2'd2;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] BYTE_ONES     = 8'hff;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;

	typedef struct packed {
		op_t               op;
		logic signed [7:0] pos_x;
		logic signed [7:0] pos_y;
		logic [1:0]        pen;
	} item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       frame_end;
	} result_t;

	typedef enum logic [1:0] {
		RD_ITEM,
		RD_SWEEP,
		RD_REFRESH
	} rd_src_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_src_t rd_src;
		logic    pix_wr;
		logic    sweep_step;
		logic    sweep_zero;
		logic    out_read;
		logic    out_refresh;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/monochrome_framebuffer_streamer_core.sv =====
// channel  | handshake                   | payload
// item     | item_valid / item_ready     | item   (op, pos_x, pos_y, pen)
// result   | result_valid / result_ready | result (out_kind, out_byte, frame_end)
//
// one item at a time; a draw reads the byte when the item is taken and writes it back in S_PIX
// read and refresh wait in S_READ / S_REFRESH while the output beat register is still full
// fill sweeps the store one byte a cycle, then passes through S_TAIL
// after reset a clearing pass over the whole store runs before item_ready
// a waiting result does not block draw or fill beats
`include "monochrome_framebuffer_streamer_core_macros.svh"

module monochrome_framebuffer_streamer_core import mfs_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int ROWS    = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	cmd_t    cmd;
	status_t status;

	mfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	mfs_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`MFS_ASSERT_IMP(a_no_accept_in_sweep, clk, arst_n, item_ready, !cmd.sweep_step)
	`MFS_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_read || cmd.out_refresh, status.out_free)
	`MFS_ASSERT_IMP(a_pix_not_sweep, clk, arst_n, cmd.pix_wr, !cmd.sweep_step && !item_ready)
	`MFS_ASSERT_IMP(a_frame_end_data, clk, arst_n, result_valid && result.frame_end, result.out_kind == KIND_DATA)

endmodule

// ===== rtl/mfs_ctrl.sv =====
module mfs_ctrl import mfs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  op_t     item_op,
	output logic    item_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_TAIL,
		S_IDLE,
		S_PIX,
		S_FILL,
		S_READ,
		S_REFRESH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd        = '0;
		cmd.rd_src = RD_ITEM;
		item_ready = 1'b0;
		state_d    = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep_step = 1'b1;
				cmd.sweep_zero = 1'b1;
				if (status.sweep_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_IDLE;
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					cmd.rd_en   = 1'b1;
					case (item_op)
						OP_DRAW:    state_d = S_PIX;
						OP_FILL:    state_d = S_FILL;
						OP_READ:    state_d = S_READ;
						OP_REFRESH: begin
							cmd.rd_src = RD_REFRESH;
							state_d    = S_REFRESH;
						end
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_PIX: begin
				cmd.pix_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_FILL: begin
				cmd.sweep_step = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_src     = RD_SWEEP;
				if (status.sweep_last) begin
					state_d = S_TAIL;
				end
			end
			S_READ: begin
				if (status.out_free) begin
					cmd.out_read = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_REFRESH: begin
				if (status.out_free) begin
					cmd.out_refresh = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/mfs_datapath.sv =====
module mfs_datapath import mfs_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int ROWS    = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output status_t status,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int PAGES = (ROWS + 7) / 8;
	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int SW    = $clog2(COLUMNS + 3);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;

	logic [AW-1:0] addr_q;
	logic [2:0]    bit_q;
	logic [1:0]    pen_q;
	logic          ok_q;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] wa_s1;
	logic          wv_s1;
	logic          wz_s1;

	logic [PW-1:0] page_q;
	logic [SW-1:0] slot_q;

	logic          out_valid_q;
	result_t       out_q;

	logic          item_ok;
	logic [AW-1:0] item_addr;
	logic [SW-1:0] ref_col;
	logic [AW-1:0] ref_addr;
	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;
	logic [7:0]    mask;
	logic [7:0]    pix_byte;
	logic [7:0]    fill_byte;
	logic          slot_cmd;
	logic          slot_end;
	logic          page_end;

	assign item_ok = !item.pos_x[7] && !item.pos_y[7]
		&& (int'(item.pos_x[6:0]) < COLUMNS) && (int'(item.pos_y[6:0]) < ROWS);
	assign item_addr = AW'(AW'(PW'(item.pos_y[6:3])) * AW'(COLUMNS))
		+ AW'(item.pos_x[6:0]);

	assign slot_cmd = slot_q < SW'(3);
	assign slot_end = slot_q == SW'(COLUMNS + 2);
	assign page_end = page_q == PW'(PAGES - 1);
	assign ref_col  = slot_cmd ? '0 : slot_q - SW'(3);
	assign ref_addr = AW'(AW'(page_q) * AW'(COLUMNS)) + AW'(ref_col);

	always_comb begin
		case (cmd.rd_src)
			RD_SWEEP:   ra = cnt_q;
			RD_REFRESH: ra = ref_addr;
			default:    ra = item_addr;
		endcase
	end

	assign mask = 8'd1 << bit_q;

	always_comb begin
		case (pen_q)
			PEN_SET:    pix_byte = rd_q | mask;
			PEN_INVERT: pix_byte = rd_q ^ mask;
			default:    pix_byte = rd_q & ~mask;
		endcase
		case (pen_q)
			PEN_SET:   fill_byte = BYTE_ONES;
			PEN_ERASE: fill_byte = BYTE_ZERO;
			default:   fill_byte = ~rd_q;
		endcase
	end

	always_comb begin
		if (wv_s1) begin
			we = 1'b1;
			wa = wa_s1;
			wd = wz_s1 ? BYTE_ZERO : fill_byte;
		end else begin
			we = cmd.pix_wr && ok_q;
			wa = addr_q;
			wd = pix_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= item_addr;
			bit_q  <= item.pos_y[2:0];
			pen_q  <= item.pen;
			ok_q   <= item_ok;
		end
		wa_s1 <= cnt_q;
	end

	// sweep counter and delayed sweep write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wv_s1 <= 1'b0;
			wz_s1 <= 1'b0;
		end else begin
			wv_s1 <= cmd.sweep_step;
			wz_s1 <= cmd.sweep_zero;
			if (cmd.sweep_step) begin
				cnt_q <= status.sweep_last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	assign status.sweep_last = cnt_q == AW'(DEPTH - 1);
	assign status.out_free   = !out_valid_q || result_ready;

	// refresh position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			slot_q <= '0;
		end else if (cmd.out_refresh) begin
			if (slot_end) begin
				slot_q <= '0;
				page_q <= page_end ? '0 : page_q + PW'(1);
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_read || cmd.out_refresh) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_read) begin
			out_q.out_kind  <= KIND_READ;
			out_q.out_byte  <= ok_q ? rd_q : BYTE_ZERO;
			out_q.frame_end <= 1'b0;
		end else if (cmd.out_refresh) begin
			if (slot_cmd) begin
				out_q.out_kind  <= KIND_CMD;
				out_q.frame_end <= 1'b0;
				if (slot_q == SW'(0)) begin
					out_q.out_byte <= CMD_PAGE_BASE + 8'(page_q);
				end else if (slot_q == SW'(1)) begin
					out_q.out_byte <= CMD_COL_HIGH;
				end else begin
					out_q.out_byte <= CMD_COL_LOW;
				end
			end else begin
				out_q.out_kind  <= KIND_DATA;
				out_q.out_byte  <= rd_q;
				out_q.frame_end <= slot_end && page_end;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== tb/sv/monochrome_framebuffer_streamer_core_tb.sv =====
module monochrome_framebuffer_streamer_core_tb;
	import mfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS      = 128;
	localparam int ROWS      = 64;
	localparam int PAGES     = (ROWS + 7) / 8;
	localparam int FB_BYTES  = COLS * PAGES;
	localparam int IDLE_PCT  = 36;
	localparam int RAND_ITEMS = 825;
	localparam int CYCLE_LIMIT = 500000;

	// shadow copy of the panel buffer and the refresh walk
	class fb_shadow;
		logic [7:0]  pixels [FB_BYTES];
		int unsigned page;
		int unsigned slot;
		int unsigned errors;
		result_t     owed_beats [$];

		function new();
			foreach (pixels[i])
				pixels[i] = BYTE_ZERO;
			page   = 0;
			slot   = 0;
			errors = 0;
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction

		function void apply_item(item_t it);
			int         x;
			int         y;
			int         a;
			bit         on;
			logic [7:0] m;
			result_t    r;
			int         col;
			x  = $signed(it.pos_x);
			y  = $signed(it.pos_y);
			on = x >= 0 && x < COLS && y >= 0 && y < ROWS;
			a  = on ? (y / 8) * COLS + x : 0;
			m  = 8'(1 << (y & 7));
			r  = '0;
			case (it.op)
				OP_DRAW: begin
					if (on) begin
						case (it.pen)
							PEN_SET:    pixels[a] = pixels[a] | m;
							PEN_INVERT: pixels[a] = pixels[a] ^ m;
							default:    pixels[a] = pixels[a] & ~m;
						endcase
					end
				end
				OP_FILL: begin
					foreach (pixels[i]) begin
						case (it.pen)
							PEN_SET:   pixels[i] = BYTE_ONES;
							PEN_ERASE: pixels[i] = BYTE_ZERO;
							default:   pixels[i] = ~pixels[i];
						endcase
					end
				end
				OP_READ: begin
					r.out_kind = KIND_READ;
					r.out_byte = on ? pixels[a] : BYTE_ZERO;
					owed_beats.push_back(r);
				end
				default: begin
					if (slot < 3) begin
						r.out_kind = KIND_CMD;
						if (slot == 0)
							r.out_byte = CMD_PAGE_BASE + 8'(page);
						else if (slot == 1)
							r.out_byte = CMD_COL_HIGH;
						else
							r.out_byte = CMD_COL_LOW;
						slot++;
					end else begin
						col = slot - 3;
						r.out_kind = KIND_DATA;
						r.out_byte = pixels[page * COLS + col];
						if (col + 1 >= COLS) begin
							slot = 0;
							if (page + 1 >= PAGES) begin
								page        = 0;
								r.frame_end = 1'b1;
							end else begin
								page++;
							end
						end else begin
							slot++;
						end
					end
					owed_beats.push_back(r);
				end
			endcase
		endfunction

		function void compare_beat(result_t got);
			result_t want;
			if (owed_beats.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = owed_beats.pop_front();
			if (got.out_kind !== want.out_kind) begin
				$display("%0t: out_kind expected %0d actual %0d", $time,
					want.out_kind, got.out_kind);
				errors++;
			end
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %h actual %h", $time,
					want.out_byte, got.out_byte);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$display("%0t: frame_end expected %0d actual %0d", $time,
					want.frame_end, got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	fb_shadow sb;
	bit       quiet;

	monochrome_framebuffer_streamer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// results first: a beat leaving at this edge belongs to an earlier item
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.compare_beat(result);
			if (item_valid && item_ready)
				sb.apply_item(item);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	function automatic item_t mk(op_t o, int x, int y, int p);
		item_t it;
		it.op    = o;
		it.pos_x = 8'(x);
		it.pos_y = 8'(y);
		it.pen   = 2'(p);
		return it;
	endfunction

	function automatic int rand_coord(int lim);
		if ($urandom_range(9) == 0)
			return $signed(8'($urandom_range(255)));
		return $urandom_range(lim - 1);
	endfunction

	function automatic item_t rand_item();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return mk(OP_FILL, rand_coord(COLS), rand_coord(ROWS), $urandom_range(3));
		if (r < 22)
			return mk(OP_DRAW, rand_coord(COLS), rand_coord(ROWS), $urandom_range(3));
		if (r < 32)
			return mk(OP_READ, rand_coord(COLS), rand_coord(ROWS), $urandom_range(3));
		return mk(OP_REFRESH, rand_coord(COLS), rand_coord(ROWS), $urandom_range(3));
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		sb           = new();
		quiet        = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_item(mk(OP_READ, 0, 0, PEN_ERASE));
		send_item(mk(OP_DRAW, 0, 0, PEN_SET));
		send_item(mk(OP_DRAW, 127, 63, PEN_SET));
		send_item(mk(OP_DRAW, 127, 62, PEN_INVERT));
		send_item(mk(OP_DRAW, 127, 62, PEN_INVERT));
		send_item(mk(OP_READ, 127, 60, PEN_SET));
		send_item(mk(OP_READ, 0, 7, PEN_SET));
		// pen three on a draw clears
		send_item(mk(OP_DRAW, 0, 0, 3));
		send_item(mk(OP_READ, 0, 0, PEN_ERASE));
		// off-screen draws and reads
		send_item(mk(OP_DRAW, -128, 5, PEN_SET));
		send_item(mk(OP_DRAW, 5, 64, PEN_SET));
		send_item(mk(OP_DRAW, 5, -1, PEN_SET));
		send_item(mk(OP_READ, -1, 10, PEN_ERASE));
		send_item(mk(OP_READ, 10, 127, PEN_ERASE));
		send_item(mk(OP_FILL, 0, 0, PEN_SET));
		send_item(mk(OP_READ, 64, 32, PEN_ERASE));
		// pen three on a fill inverts
		send_item(mk(OP_FILL, 0, 0, 3));
		send_item(mk(OP_READ, 64, 32, PEN_ERASE));
		send_item(mk(OP_FILL, 0, 0, PEN_INVERT));
		send_item(mk(OP_DRAW, 3, 9, PEN_ERASE));
		send_item(mk(OP_REFRESH, 0, 0, PEN_ERASE));
		send_item(mk(OP_REFRESH, 0, 0, PEN_ERASE));
		send_item(mk(OP_REFRESH, 0, 0, PEN_ERASE));
		send_item(mk(OP_REFRESH, 0, 0, PEN_ERASE));
		send_item(mk(OP_FILL, 0, 0, PEN_ERASE));

		// random traffic
		n = 0;
		while (n < RAND_ITEMS) begin
			quiet = n >= 200 && n < 400;
			if (n == 100 || n == 500)
				drain();
			send_item(rand_item());
			n++;
		end

		quiet = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== monochrome_framebuffer_streamer_core.f =====
+incdir+rtl
rtl/mfs_pkg.sv
rtl/mfs_ctrl.sv
rtl/mfs_datapath.sv
rtl/monochrome_framebuffer_streamer_core.sv
tb/sv/monochrome_framebuffer_streamer_core_tb.sv
